@@ src/pms_pkg.sv @@
`default_nettype none

package pms_pkg;

    localparam logic [15:0] DEFAULT_CONFIG_WORD = 16'd14751;
    localparam logic [15:0] CONFIG_RESET_BIT    = 16'h8000;

    // Input commands
    localparam logic [2:0] CMD_START     = 3'd0;
    localparam logic [2:0] CMD_DONE      = 3'd1;
    localparam logic [2:0] CMD_ERROR     = 3'd2;
    localparam logic [2:0] CMD_REQ_CFG   = 3'd3;
    localparam logic [2:0] CMD_REQ_BUS   = 3'd4;
    localparam logic [2:0] CMD_REQ_SHUNT = 3'd5;
    localparam logic [2:0] CMD_REQ_CUR   = 3'd6;

    // Message kinds
    localparam logic [1:0] MSG_NONE  = 2'd0;
    localparam logic [1:0] MSG_WRITE = 2'd1;
    localparam logic [1:0] MSG_READ  = 2'd2;

    // Device register pointers
    localparam logic [2:0] PTR_CONFIG  = 3'd0;
    localparam logic [2:0] PTR_SHUNT   = 3'd1;
    localparam logic [2:0] PTR_BUS     = 3'd2;
    localparam logic [2:0] PTR_CURRENT = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_BUS_RANGE  = 3'd0;
    localparam logic [2:0] CFG_PGA_GAIN   = 3'd1;
    localparam logic [2:0] CFG_BUS_ADC    = 3'd2;
    localparam logic [2:0] CFG_SHUNT_ADC  = 3'd3;
    localparam logic [2:0] CFG_OP_MODE    = 3'd4;
    localparam logic [2:0] CFG_SHUNT_RES  = 3'd5;

    // Write word selection
    localparam logic [1:0] WSEL_ZERO   = 2'd0;
    localparam logic [1:0] WSEL_SHADOW = 2'd1;
    localparam logic [1:0] WSEL_RESET  = 2'd2;

    // Read word destination
    localparam logic [2:0] STORE_NONE  = 3'd0;
    localparam logic [2:0] STORE_CFG   = 3'd1;
    localparam logic [2:0] STORE_CUR   = 3'd2;
    localparam logic [2:0] STORE_SHUNT = 3'd3;
    localparam logic [2:0] STORE_BUS   = 3'd4;

    // Conversion constants
    localparam int UV_PER_LSB    = 10;
    localparam int UA_PER_UV_MA  = 1000;
    localparam int BUS_UV_PER_LSB = 4000;
    localparam int QUO_W         = 29;   // |shunt_uv| * 1000 fits 29 bits
    localparam int DIV_CNT_W     = $clog2(QUO_W);

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] read_data;
    } in_payload_t;

    typedef struct packed {
        logic [1:0]         msg_kind;
        logic [2:0]         reg_pointer;
        logic [15:0]        write_word;
        logic               init_done;
        logic               start_requested;
        logic [15:0]        config_word;
        logic [15:0]        bus_raw;
        logic [15:0]        shunt_raw;
        logic [15:0]        current_raw;
        logic signed [19:0] shunt_uv;
        logic [24:0]        bus_uv;
        logic signed [29:0] current_ua;
    } out_payload_t;

    typedef struct packed {
        logic       step;
        logic       rebuild_cfg;
        logic [1:0] msg_kind;
        logic [2:0] msg_ptr;
        logic [1:0] wsel;
        logic [2:0] store_sel;
        logic       mul_load;
        logic       div_step;
        logic       load_out;
        logic       init_done;
        logic       start_requested;
    } ctrl_cmd_t;

    typedef struct packed {
        logic shadow_is_default;
        logic data_is_default;
    } dp_status_t;

endpackage

`default_nettype wire

@@ src/pms_if.sv @@
`default_nettype none

interface pms_in_if;
    import pms_pkg::*;

    logic        valid;
    logic        ready;
    in_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface pms_out_if;
    import pms_pkg::*;

    logic         valid;
    logic         ready;
    out_payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/power_monitor_poll_sequencer_top.sv @@
`default_nettype none
// A result passes the multiply phase, the 29-step restoring divider for the
// current conversion and the load phase, which waits for a free output register.
// No new transaction is accepted while one is still in those phases.
// The input is ready again as soon as the result is in the output register.
// Reset (rst_n low, asynchronous): idle, all requests pending, registers at
// their defaults, configuration word 0x399F, stored words zero.

module power_monitor_poll_sequencer_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    pms_in_if.sink           in_ch,
    pms_out_if.source        out_ch
);
    import pms_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    pms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_cmd    (in_ch.payload.cmd),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .read_data (in_ch.payload.read_data),
        .cmd       (cmd),
        .status    (status),
        .payload   (out_ch.payload)
    );

endmodule

`default_nettype wire

@@ src/pms_ctrl.sv @@
`default_nettype none

module pms_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        in_cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire pms_pkg::dp_status_t status,
    output pms_pkg::ctrl_cmd_t     cmd
);
    import pms_pkg::*;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;
    localparam logic [1:0] P_OUT  = 2'd3;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INIT_RST = 3'd1;
    localparam logic [2:0] ST_INIT_RB  = 3'd2;
    localparam logic [2:0] ST_INIT_WR  = 3'd3;
    localparam logic [2:0] ST_RD_CFG   = 3'd4;
    localparam logic [2:0] ST_RD_CUR   = 3'd5;
    localparam logic [2:0] ST_RD_SHUNT = 3'd6;
    localparam logic [2:0] ST_RD_BUS   = 3'd7;

    localparam int FL_INIT  = 0;
    localparam int FL_CFG   = 1;
    localparam int FL_CUR   = 2;
    localparam int FL_SHUNT = 3;
    localparam int FL_BUS   = 4;
    localparam logic [4:0] FL_ALL = 5'b11111;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

    logic [1:0]           phase_reg, phase_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [2:0]           seq_state_reg, seq_next, seq_eff;
    logic [4:0]           flags_reg, flags_next, flags_eff;
    logic                 init_flag_reg, init_next;
    logic                 error_flag_reg, error_next;
    logic                 accept;
    logic                 slot_free;

    logic [1:0] msg_kind;
    logic [2:0] msg_ptr;
    logic [1:0] wsel;
    logic [2:0] store_sel;
    logic       rebuild;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (phase_reg == P_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Poll sequencer: one transaction updates flags, state and message
    always_comb
    begin
        seq_next   = seq_state_reg;
        flags_next = flags_reg;
        init_next  = init_flag_reg;
        error_next = error_flag_reg;
        seq_eff    = seq_state_reg;
        flags_eff  = flags_reg;
        msg_kind   = MSG_NONE;
        msg_ptr    = PTR_CONFIG;
        wsel       = WSEL_ZERO;
        store_sel  = STORE_NONE;
        rebuild    = 1'b0;
        if (accept)
        begin
            unique case (in_cmd)
                CMD_START:
                begin
                    // recover from a failed transfer before serving anything
                    if (error_flag_reg)
                    begin
                        error_next = 1'b0;
                        seq_eff    = ST_IDLE;
                        init_next  = 1'b0;
                        flags_eff  = FL_ALL;
                        rebuild    = 1'b1;
                    end
                    seq_next   = seq_eff;
                    flags_next = flags_eff;
                    if (seq_eff == ST_IDLE)
                    begin
                        priority if (flags_eff[FL_INIT])
                        begin
                            flags_next[FL_INIT] = 1'b0;
                            seq_next = ST_INIT_RST;
                            msg_kind = MSG_WRITE;
                            wsel     = WSEL_RESET;
                        end
                        else if (flags_eff[FL_CFG])
                        begin
                            flags_next[FL_CFG] = 1'b0;
                            seq_next = ST_RD_CFG;
                            msg_kind = MSG_READ;
                        end
                        else if (flags_eff[FL_CUR])
                        begin
                            flags_next[FL_CUR] = 1'b0;
                            seq_next = ST_RD_CUR;
                            msg_kind = MSG_READ;
                            msg_ptr  = PTR_CURRENT;
                        end
                        else if (flags_eff[FL_SHUNT])
                        begin
                            flags_next[FL_SHUNT] = 1'b0;
                            seq_next = ST_RD_SHUNT;
                            msg_kind = MSG_READ;
                            msg_ptr  = PTR_SHUNT;
                        end
                        else if (flags_eff[FL_BUS])
                        begin
                            flags_next[FL_BUS] = 1'b0;
                            seq_next = ST_RD_BUS;
                            msg_kind = MSG_READ;
                            msg_ptr  = PTR_BUS;
                        end
                        else
                        begin
                            seq_next = ST_IDLE;
                        end
                    end
                end
                CMD_DONE:
                begin
                    unique case (seq_state_reg)
                        ST_INIT_RST:
                        begin
                            seq_next = ST_INIT_RB;
                            msg_kind = MSG_READ;
                        end
                        ST_INIT_RB:
                        begin
                            seq_next = ST_IDLE;
                            if (status.data_is_default)
                            begin
                                if (!status.shadow_is_default)
                                begin
                                    seq_next = ST_INIT_WR;
                                    msg_kind = MSG_WRITE;
                                    wsel     = WSEL_SHADOW;
                                end
                                else
                                begin
                                    init_next = 1'b1;
                                end
                            end
                            else
                            begin
                                // readback mismatch: re-arm init
                                init_next = 1'b0;
                                flags_next[FL_INIT] = 1'b1;
                            end
                        end
                        ST_INIT_WR:
                        begin
                            init_next = 1'b1;
                            seq_next  = ST_IDLE;
                        end
                        ST_RD_CFG:
                        begin
                            store_sel = STORE_CFG;
                            seq_next  = ST_IDLE;
                        end
                        ST_RD_CUR:
                        begin
                            store_sel = STORE_CUR;
                            seq_next  = ST_IDLE;
                        end
                        ST_RD_SHUNT:
                        begin
                            store_sel = STORE_SHUNT;
                            seq_next  = ST_IDLE;
                        end
                        ST_RD_BUS:
                        begin
                            store_sel = STORE_BUS;
                            seq_next  = ST_IDLE;
                        end
                        default:
                        begin
                            seq_next = seq_state_reg;
                        end
                    endcase
                end
                CMD_ERROR:     error_next = 1'b1;
                CMD_REQ_CFG:   flags_next[FL_CFG]   = 1'b1;
                CMD_REQ_BUS:   flags_next[FL_BUS]   = 1'b1;
                CMD_REQ_SHUNT: flags_next[FL_SHUNT] = 1'b1;
                CMD_REQ_CUR:   flags_next[FL_CUR]   = 1'b1;
                default:       error_next = error_flag_reg;
            endcase
        end
    end

    // Item phases: step on accept, multiply, divide, load result
    always_comb
    begin
        phase_next     = phase_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (phase_reg)
            P_IDLE:
            begin
                if (accept)
                begin
                    phase_next = P_MUL;
                end
            end
            P_MUL:
            begin
                phase_next   = P_DIV;
                div_cnt_next = '0;
            end
            P_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    phase_next = P_OUT;
                end
            end
            P_OUT:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    phase_next     = P_IDLE;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.step            = accept;
        cmd.rebuild_cfg     = rebuild;
        cmd.msg_kind        = msg_kind;
        cmd.msg_ptr         = msg_ptr;
        cmd.wsel            = wsel;
        cmd.store_sel       = store_sel;
        cmd.mul_load        = (phase_reg == P_MUL);
        cmd.div_step        = (phase_reg == P_DIV);
        cmd.load_out        = (phase_reg == P_OUT) && slot_free;
        cmd.init_done       = init_flag_reg;
        cmd.start_requested = |flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= P_IDLE;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            seq_state_reg  <= ST_IDLE;
            flags_reg      <= FL_ALL;
            init_flag_reg  <= 1'b0;
            error_flag_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
            seq_state_reg  <= seq_next;
            flags_reg      <= flags_next;
            init_flag_reg  <= init_next;
            error_flag_reg <= error_next;
        end
    end

    a_accept_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> phase_reg == P_MUL)
        else $error("accepted transaction did not enter the multiply phase");

    a_div_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == P_DIV && div_cnt_reg == DIV_LAST) |=> phase_reg == P_OUT)
        else $error("divider did not finish after its last step");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(phase_reg) == P_OUT)
        else $error("result raised outside the load phase");

    a_recovery: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_cmd == CMD_START && error_flag_reg)
            |=> (!error_flag_reg && !init_flag_reg && seq_state_reg == ST_INIT_RST))
        else $error("error recovery did not restart init");

endmodule

`default_nettype wire

@@ src/pms_dp.sv @@
`default_nettype none

module pms_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [15:0]         read_data,
    input  wire pms_pkg::ctrl_cmd_t  cmd,
    output pms_pkg::dp_status_t      status,
    output pms_pkg::out_payload_t    payload
);
    import pms_pkg::*;

    localparam logic [13:0] MUL_SCALE = 14'(UV_PER_LSB * UA_PER_UV_MA);
    localparam logic signed [19:0] SUV_SCALE = 20'sd10;
    localparam logic [24:0] BUS_SCALE = 25'(BUS_UV_PER_LSB);

    logic        bus_range_reg, bus_range_next;
    logic [1:0]  pga_gain_reg, pga_gain_next;
    logic [3:0]  bus_adc_reg, bus_adc_next;
    logic [3:0]  shunt_adc_reg, shunt_adc_next;
    logic [2:0]  op_mode_reg, op_mode_next;
    logic [15:0] shunt_res_reg, shunt_res_next;
    logic        field_write;

    logic [15:0] shadow_reg, shadow_next, shadow_eff;
    logic [15:0] built_cur, built_next;
    logic [15:0] bus_word_reg, shunt_word_reg, current_word_reg;

    logic [1:0]  msg_kind_reg;
    logic [2:0]  msg_ptr_reg;
    logic [15:0] msg_word_reg, msg_word;

    logic             neg_reg;
    logic [16:0]      mag;
    logic [QUO_W-1:0] quo_reg;
    logic [15:0]      rem_reg;
    logic [16:0]      trial;
    logic [17:0]      diff;

    logic signed [29:0] current_ua;
    logic signed [19:0] shunt_uv;
    logic [24:0]        bus_uv;
    out_payload_t       out_reg;

    always_comb
    begin
        bus_range_next = bus_range_reg;
        pga_gain_next  = pga_gain_reg;
        bus_adc_next   = bus_adc_reg;
        shunt_adc_next = shunt_adc_reg;
        op_mode_next   = op_mode_reg;
        shunt_res_next = shunt_res_reg;
        field_write    = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BUS_RANGE:
                begin
                    bus_range_next = cfg_data[0];
                    field_write    = 1'b1;
                end
                CFG_PGA_GAIN:
                begin
                    pga_gain_next = cfg_data[1:0];
                    field_write   = 1'b1;
                end
                CFG_BUS_ADC:
                begin
                    bus_adc_next = cfg_data[3:0];
                    field_write  = 1'b1;
                end
                CFG_SHUNT_ADC:
                begin
                    shunt_adc_next = cfg_data[3:0];
                    field_write    = 1'b1;
                end
                CFG_OP_MODE:
                begin
                    op_mode_next = cfg_data[2:0];
                    field_write  = 1'b1;
                end
                CFG_SHUNT_RES: shunt_res_next = cfg_data;
                default:       field_write = 1'b0;
            endcase
        end
    end

    assign built_cur  = {2'b00, bus_range_reg, pga_gain_reg, bus_adc_reg,
                         shunt_adc_reg, op_mode_reg};
    assign built_next = {2'b00, bus_range_next, pga_gain_next, bus_adc_next,
                         shunt_adc_next, op_mode_next};

    // recovery rebuilds the word in the same transaction that sends it
    assign shadow_eff = cmd.rebuild_cfg ? built_cur : shadow_reg;

    always_comb
    begin
        priority if (field_write)
            shadow_next = built_next;
        else if (cmd.step && cmd.store_sel == STORE_CFG)
            shadow_next = read_data;
        else if (cmd.step && cmd.rebuild_cfg)
            shadow_next = built_cur;
        else
            shadow_next = shadow_reg;
    end

    always_comb
    begin
        unique case (cmd.wsel)
            WSEL_SHADOW: msg_word = shadow_eff;
            WSEL_RESET:  msg_word = shadow_eff | CONFIG_RESET_BIT;
            default:     msg_word = '0;
        endcase
    end

    assign status.shadow_is_default = (shadow_reg == DEFAULT_CONFIG_WORD);
    assign status.data_is_default   = (read_data == DEFAULT_CONFIG_WORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_range_reg    <= 1'b1;
            pga_gain_reg     <= 2'd3;
            bus_adc_reg      <= 4'd3;
            shunt_adc_reg    <= 4'd3;
            op_mode_reg      <= 3'd7;
            shunt_res_reg    <= 16'd100;
            shadow_reg       <= {2'b00, 1'b1, 2'd3, 4'd3, 4'd3, 3'd7};
            bus_word_reg     <= '0;
            shunt_word_reg   <= '0;
            current_word_reg <= '0;
        end
        else
        begin
            bus_range_reg <= bus_range_next;
            pga_gain_reg  <= pga_gain_next;
            bus_adc_reg   <= bus_adc_next;
            shunt_adc_reg <= shunt_adc_next;
            op_mode_reg   <= op_mode_next;
            shunt_res_reg <= shunt_res_next;
            shadow_reg    <= shadow_next;
            if (cmd.step && cmd.store_sel == STORE_BUS)
                bus_word_reg <= read_data;
            if (cmd.step && cmd.store_sel == STORE_SHUNT)
                shunt_word_reg <= read_data;
            if (cmd.step && cmd.store_sel == STORE_CUR)
                current_word_reg <= read_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            msg_kind_reg <= cmd.msg_kind;
            msg_ptr_reg  <= cmd.msg_ptr;
            msg_word_reg <= msg_word;
        end
    end

    // Current: |raw| * 10000 then restoring division, one quotient bit a cycle
    assign mag   = shunt_word_reg[15] ? (17'h10000 - {1'b0, shunt_word_reg})
                                      : {1'b0, shunt_word_reg};
    assign trial = {rem_reg, quo_reg[QUO_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, shunt_res_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            neg_reg <= shunt_word_reg[15];
            quo_reg <= QUO_W'(mag * MUL_SCALE);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], !diff[17]};
            rem_reg <= diff[17] ? trial[15:0] : diff[15:0];
        end
    end

    always_comb
    begin
        if (shunt_res_reg == '0)
            current_ua = '0;
        else if (neg_reg)
            current_ua = 30'sd0 - $signed({1'b0, quo_reg});
        else
            current_ua = $signed({1'b0, quo_reg});
    end

    assign shunt_uv = 20'(signed'(shunt_word_reg)) * SUV_SCALE;
    assign bus_uv   = {12'd0, bus_word_reg[15:3]} * BUS_SCALE;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.msg_kind        <= msg_kind_reg;
            out_reg.reg_pointer     <= msg_ptr_reg;
            out_reg.write_word      <= msg_word_reg;
            out_reg.init_done       <= cmd.init_done;
            out_reg.start_requested <= cmd.start_requested;
            out_reg.config_word     <= shadow_reg;
            out_reg.bus_raw         <= bus_word_reg;
            out_reg.shunt_raw       <= shunt_word_reg;
            out_reg.current_raw     <= current_word_reg;
            out_reg.shunt_uv        <= shunt_uv;
            out_reg.bus_uv          <= bus_uv;
            out_reg.current_ua      <= current_ua;
        end
    end

    assign payload = out_reg;

endmodule

`default_nettype wire
